// File: rtl/core/sseg_pkg.sv
package sseg_pkg;

   localparam int RAM_DEPTH   = 16;
   localparam int ADDR_W      = 4;
   localparam int DIGIT_SLOTS = 4;
   localparam int SCAN_W      = 2;

   localparam logic [3:0] CMD_SET_ADDR = 4'h0;
   localparam logic [3:0] CMD_DIMMING  = 4'hE;

   localparam logic [ADDR_W-1:0] COLON_ADDR = 4'd4;
   localparam logic [ADDR_W-1:0] LEFT_ADDR  = 4'd2;
   localparam logic [ADDR_W-1:0] RIGHT_ADDR = 4'd6;
   localparam logic [7:0]        COLON_ON   = 8'h02;
   localparam logic [7:0]        COLON_OFF  = 8'h00;
   localparam logic [7:0]        DUTY_RESET = 8'd16;

   typedef logic [DIGIT_SLOTS-1:0][ADDR_W-1:0] digit_addr_type;

   localparam digit_addr_type DIGIT_RESET = {4'd8, 4'd6, 4'd2, 4'd0};

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_COLON
   } state_type;

   typedef struct packed {
      logic accept;
      logic run_colon;
   } ctrl_cmd_type;

   typedef struct packed {
      logic colon_req;
      logic queue_full;
   } ctrl_sts_type;

   typedef struct packed {
      logic [6:0] seg_d;
      logic [3:0] seg_b;
      logic [3:0] digit_sel;
      logic [7:0] duty;
   } rsp_type;

   // data bits 0,2,3,5,6 go to port D pins 6,5,4,2,3
   function automatic logic [6:0] remap_d(input logic [7:0] data);
      remap_d = {data[0], data[2], data[3], data[6], data[5], 2'b00};
   endfunction

   // data bits 7,1,4 go to port B pins 0,2,3
   function automatic logic [3:0] remap_b(input logic [7:0] data);
      remap_b = {data[4], data[1], 1'b0, data[7]};
   endfunction

endpackage

// File: rtl/core/seven_segment_display_controller.sv
// Four-digit seven-segment display controller. Each item is either a bus
// write byte or a scan tick, and each item yields exactly one result: the
// current port D / port B segment drive, the one-hot digit select and the
// brightness duty. A byte that closes a write transaction moves the controller
// into its colon state, in which it holds req_stall while the colon images
// at addresses 2 and 6 are rebuilt. Results pass through a two-entry queue,
// so input keeps flowing while a result waits; outside the colon state
// req_stall rises only when that queue is full.
// Digit addresses are set over the csr port and should be changed only while
// the block is idle.
module seven_segment_display_controller #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_bus_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_segment_port_d,
   output logic [3:0]  rsp_segment_port_b,
   output logic [3:0]  rsp_digit_select,
   output logic [7:0]  rsp_brightness_duty,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sseg_pkg::*;

   digit_addr_type digit_addr;
   ctrl_cmd_type   cmd;
   ctrl_sts_type   sts;
   rsp_type        result;
   rsp_type        head;
   logic           colon_req;
   logic           queue_full;

   assign sts.colon_req  = colon_req;
   assign sts.queue_full = queue_full;

   sseg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .digit_addr  (digit_addr)
   );

   sseg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sseg_dp #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .colon_req      (colon_req),
      .req_func       (req_func),
      .req_bus_byte   (req_bus_byte),
      .req_first_byte (req_first_byte),
      .req_final_byte (req_final_byte),
      .digit_addr     (digit_addr),
      .result         (result)
   );

   sseg_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.accept),
      .push_data (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_segment_port_d  = head.seg_d;
   assign rsp_segment_port_b  = head.seg_b;
   assign rsp_digit_select    = head.digit_sel;
   assign rsp_brightness_duty = head.duty;

endmodule

// File: rtl/core/sseg_csr.sv
module sseg_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [3:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output sseg_pkg::digit_addr_type digit_addr
);
   import sseg_pkg::*;

   digit_addr_type addr_ff;
   logic [1:0]     reg_idx;

   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = {28'd0, addr_ff[reg_idx]};
   assign digit_addr = addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= DIGIT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         addr_ff[reg_idx] <= csr_pwdata[ADDR_W-1:0];
      end
   end

endmodule

// File: rtl/core/sseg_ctrl.sv
module sseg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sseg_pkg::ctrl_sts_type sts,
   output sseg_pkg::ctrl_cmd_type cmd
);
   import sseg_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_stall     = 1'b1;
      cmd.accept    = 1'b0;
      cmd.run_colon = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall  = sts.queue_full;
            cmd.accept = req_valid && !sts.queue_full;
            if (cmd.accept && sts.colon_req) begin
               state_in = ST_COLON;
            end
         end
         ST_COLON: begin
            // rebuild the colon images, input held off
            cmd.run_colon = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/sseg_dp.sv
module sseg_dp #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sseg_pkg::ctrl_cmd_type   cmd,
   output logic                     colon_req,
   input  logic                     req_func,
   input  logic [7:0]               req_bus_byte,
   input  logic                     req_first_byte,
   input  logic                     req_final_byte,
   input  sseg_pkg::digit_addr_type digit_addr,
   output sseg_pkg::rsp_type        result
);
   import sseg_pkg::*;

   logic [7:0]        ram_ff   [RAM_DEPTH];
   logic [6:0]        img_d_ff [RAM_DEPTH];
   logic [3:0]        img_b_ff [RAM_DEPTH];
   logic [ADDR_W-1:0] ptr_ff;
   logic              write_mode_ff;
   logic              touched_ff;
   logic [7:0]        duty_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [14:0]       drive_ff;

   logic [3:0]        kind;
   logic [SCAN_W-1:0] scan_cur;
   logic [SCAN_W-1:0] scan_in;
   logic [ADDR_W-1:0] rd_addr;
   logic [14:0]       drive_in;
   logic [7:0]        duty_in;
   logic              is_cmd;
   logic              is_data;

   assign kind    = req_bus_byte[7:4];
   assign is_cmd  = !req_func && req_first_byte;
   assign is_data = !req_func && !req_first_byte && write_mode_ff;

   // a write transaction closes on this byte
   assign colon_req = !req_func && req_final_byte &&
                      (req_first_byte ? (kind == CMD_SET_ADDR) : write_mode_ff);

   always_comb begin
      scan_cur = ({1'b0, scan_ff} >= 3'(DIGIT_COUNT)) ? '0 : scan_ff;
      scan_in  = ({1'b0, scan_cur} + 3'd1 >= 3'(DIGIT_COUNT)) ? '0 : scan_cur + 1'b1;
      rd_addr  = digit_addr[scan_cur];
      drive_in = {4'(4'b0001 << scan_cur), img_b_ff[rd_addr], img_d_ff[rd_addr]};
      duty_in  = (is_cmd && kind == CMD_DIMMING) ? {req_bus_byte[3:0], 4'd0} : duty_ff;
      result.seg_d     = req_func ? drive_in[6:0]   : drive_ff[6:0];
      result.seg_b     = req_func ? drive_in[10:7]  : drive_ff[10:7];
      result.digit_sel = req_func ? drive_in[14:11] : drive_ff[14:11];
      result.duty      = duty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) begin
            ram_ff[i]   <= '0;
            img_d_ff[i] <= '0;
            img_b_ff[i] <= '0;
         end
         ptr_ff        <= '0;
         write_mode_ff <= 1'b0;
         touched_ff    <= 1'b0;
         duty_ff       <= DUTY_RESET;
         scan_ff       <= '0;
         drive_ff      <= '0;
      end else begin
         if (cmd.accept) begin
            if (req_func) begin
               drive_ff <= drive_in;
               scan_ff  <= scan_in;
            end else if (is_cmd) begin
               write_mode_ff <= (kind == CMD_SET_ADDR);
               touched_ff    <= 1'b0;
               duty_ff       <= duty_in;
               if (kind == CMD_SET_ADDR) begin
                  ptr_ff <= req_bus_byte[ADDR_W-1:0];
               end
            end else if (is_data) begin
               ram_ff[ptr_ff]   <= req_bus_byte;
               img_d_ff[ptr_ff] <= remap_d(req_bus_byte);
               img_b_ff[ptr_ff] <= remap_b(req_bus_byte);
               if (ptr_ff == COLON_ADDR) begin
                  touched_ff <= 1'b1;
               end
               ptr_ff <= ptr_ff + 1'b1;
            end
         end
         if (cmd.run_colon) begin
            if (touched_ff && ram_ff[COLON_ADDR] == COLON_ON) begin
               img_b_ff[LEFT_ADDR]  <= remap_b(ram_ff[LEFT_ADDR] | 8'h80);
               img_b_ff[RIGHT_ADDR] <= remap_b(ram_ff[RIGHT_ADDR] | 8'h80);
            end else if (touched_ff && ram_ff[COLON_ADDR] == COLON_OFF) begin
               img_b_ff[LEFT_ADDR]  <= remap_b(ram_ff[LEFT_ADDR]);
               img_b_ff[RIGHT_ADDR] <= remap_b(ram_ff[RIGHT_ADDR] & 8'h7F);
            end else begin
               img_b_ff[RIGHT_ADDR] <= remap_b(ram_ff[RIGHT_ADDR] & 8'h7F);
            end
            write_mode_ff <= 1'b0;
            touched_ff    <= 1'b0;
         end
      end
   end

endmodule

// File: rtl/core/sseg_outq.sv
module sseg_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sseg_pkg::rsp_type push_data,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sseg_pkg::rsp_type head
);
   import sseg_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign head      = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: rtl/core/sseg_checker.sv
module sseg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [6:0] rsp_segment_port_d,
   input logic [3:0] rsp_segment_port_b,
   input logic [3:0] rsp_digit_select,
   input logic [7:0] rsp_brightness_duty
);

   // no result can be pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segment_port_d) &&
         $stable(rsp_segment_port_b) && $stable(rsp_digit_select) &&
         $stable(rsp_brightness_duty))
      else $error("stalled result changed");

   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0(rsp_digit_select))
      else $error("digit select not one-hot");

   // duty is a nibble times sixteen
   a_duty_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_brightness_duty[3:0] == 4'd0)
      else $error("brightness duty off its step");

   // unused pins of both ports never drive
   a_unused_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_port_d[1:0] == 2'd0 && rsp_segment_port_b[1] == 1'b0)
      else $error("unused segment pin driven");

endmodule

bind seven_segment_display_controller sseg_checker u_sseg_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_segment_port_d  (rsp_segment_port_d),
   .rsp_segment_port_b  (rsp_segment_port_b),
   .rsp_digit_select    (rsp_digit_select),
   .rsp_brightness_duty (rsp_brightness_duty)
);

// File: tb/sv/sseg_tb_pkg.sv
`timescale 1ns / 1ps
package sseg_tb_pkg;

   typedef enum logic {
      FUNC_BUS_BYTE  = 1'b0,
      FUNC_SCAN_TICK = 1'b1
   } func_type;

   typedef enum int {
      REG_DIGIT0,
      REG_DIGIT1,
      REG_DIGIT2,
      REG_DIGIT3
   } csr_reg_type;

   localparam int CSR_STRIDE = 4;

endpackage

// File: tb/sv/sseg_display_checker.sv
`timescale 1ns / 1ps
module sseg_display_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_bus_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_segment_port_d,
   input  logic [3:0]  rsp_segment_port_b,
   input  logic [3:0]  rsp_digit_select,
   input  logic [7:0]  rsp_brightness_duty,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          error_count,
   output int          pending_count
);
   import sseg_pkg::*;
   import sseg_tb_pkg::*;

   logic [7:0]        seg_ram [RAM_DEPTH];
   logic [6:0]        d_image [RAM_DEPTH];
   logic [3:0]        b_image [RAM_DEPTH];
   logic [ADDR_W-1:0] write_ptr;
   logic              in_write;
   logic              colon_written;
   logic [7:0]        duty;
   logic [SCAN_W-1:0] scan_pos;
   logic [6:0]        held_d;
   logic [3:0]        held_b;
   logic [3:0]        held_sel;
   digit_addr_type    digit_addr;
   rsp_type           drive_queue [$];

   // pin positions: bit0->6, bit2->5, bit3->4, bit6->3, bit5->2
   function automatic logic [6:0] port_d_pins(input logic [7:0] v);
      logic [6:0] p;
      p = '0;
      p[6] = v[0];
      p[5] = v[2];
      p[4] = v[3];
      p[3] = v[6];
      p[2] = v[5];
      return p;
   endfunction

   // pin positions: bit7->0, bit1->2, bit4->3
   function automatic logic [3:0] port_b_pins(input logic [7:0] v);
      logic [3:0] p;
      p = '0;
      p[0] = v[7];
      p[2] = v[1];
      p[3] = v[4];
      return p;
   endfunction

   task automatic close_write();
      logic [7:0] colon;
      colon = seg_ram[COLON_ADDR];
      if (colon_written && colon == COLON_ON) begin
         b_image[LEFT_ADDR]  = port_b_pins(seg_ram[LEFT_ADDR] | 8'h80);
         b_image[RIGHT_ADDR] = port_b_pins(seg_ram[RIGHT_ADDR] | 8'h80);
      end else if (colon_written && colon == COLON_OFF) begin
         b_image[LEFT_ADDR]  = port_b_pins(seg_ram[LEFT_ADDR]);
         b_image[RIGHT_ADDR] = port_b_pins(seg_ram[RIGHT_ADDR] & 8'h7F);
      end else begin
         b_image[RIGHT_ADDR] = port_b_pins(seg_ram[RIGHT_ADDR] & 8'h7F);
      end
      in_write      = 1'b0;
      colon_written = 1'b0;
   endtask

   task automatic predict_drive(input logic f, input logic [7:0] b, input logic fb,
                                input logic lb, output rsp_type drive);
      logic [ADDR_W-1:0] a;
      if (f == FUNC_SCAN_TICK) begin
         a        = digit_addr[scan_pos];
         held_d   = d_image[a];
         held_b   = b_image[a];
         held_sel = 4'b0001 << scan_pos;
         scan_pos = scan_pos + 1'b1;
      end else if (fb) begin
         in_write      = 1'b0;
         colon_written = 1'b0;
         if (b[7:4] == CMD_SET_ADDR) begin
            write_ptr = b[3:0];
            in_write  = 1'b1;
         end else if (b[7:4] == CMD_DIMMING) begin
            duty = {b[3:0], 4'b0000};
         end
         if (lb && in_write)
            close_write();
      end else if (in_write) begin
         seg_ram[write_ptr] = b;
         d_image[write_ptr] = port_d_pins(b);
         b_image[write_ptr] = port_b_pins(b);
         if (write_ptr == COLON_ADDR)
            colon_written = 1'b1;
         write_ptr = write_ptr + 1'b1;
         if (lb)
            close_write();
      end
      drive.seg_d     = held_d;
      drive.seg_b     = held_b;
      drive.digit_sel = held_sel;
      drive.duty      = duty;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) begin
            seg_ram[i] = '0;
            d_image[i] = '0;
            b_image[i] = '0;
         end
         write_ptr     = '0;
         in_write      = 1'b0;
         colon_written = 1'b0;
         duty          = DUTY_RESET;
         scan_pos      = '0;
         held_d        = '0;
         held_b        = '0;
         held_sel      = '0;
         digit_addr    = DIGIT_RESET;
         drive_queue.delete();
         error_count   = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            digit_addr[csr_paddr[3:2]] = csr_pwdata[ADDR_W-1:0];
         if (req_valid && !req_stall) begin
            predict_drive(req_func, req_bus_byte, req_first_byte, req_final_byte, want);
            drive_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_queue.size() == 0) begin
               $error("result item with no expectation pending");
               error_count++;
            end else begin
               want = drive_queue.pop_front();
               if (rsp_segment_port_d !== want.seg_d) begin
                  $error("segment_port_d: expected %0h, got %0h", want.seg_d,
                         rsp_segment_port_d);
                  error_count++;
               end
               if (rsp_segment_port_b !== want.seg_b) begin
                  $error("segment_port_b: expected %0h, got %0h", want.seg_b,
                         rsp_segment_port_b);
                  error_count++;
               end
               if (rsp_digit_select !== want.digit_sel) begin
                  $error("digit_select: expected %0h, got %0h", want.digit_sel,
                         rsp_digit_select);
                  error_count++;
               end
               if (rsp_brightness_duty !== want.duty) begin
                  $error("brightness_duty: expected %0h, got %0h", want.duty,
                         rsp_brightness_duty);
                  error_count++;
               end
            end
         end
      end
      pending_count <= drive_queue.size();
   end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import sseg_pkg::*;
   import sseg_tb_pkg::*;

   localparam int         IDLE_LIMIT   = 4000;
   localparam int         PHASES       = 5;
   localparam int         RANDOM_ITEMS = 1300;
   localparam logic [3:0] CMD_OTHER    = 4'h7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_func;
   logic [7:0]  req_bus_byte;
   logic        req_first_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_segment_port_d;
   logic [3:0]  rsp_segment_port_b;
   logic [3:0]  rsp_digit_select;
   logic [7:0]  rsp_brightness_duty;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          error_count;
   int          pending_count;
   int          items_sent = 0;
   bit          quiet = 1'b0;

   always #4 clock = ~clock;

   seven_segment_display_controller dut (.*);

   sseg_display_checker u_checker (.*);

   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 33);

   // ends the run when neither channel nor the csr port moves for too long
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_psel && csr_penable && csr_pwrite))
            stuck = 0;
         else
            stuck++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send(input func_type f, input logic [7:0] b, input logic fb,
                       input logic lb);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_bus_byte   <= b;
      req_first_byte <= fb;
      req_final_byte <= lb;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic write_reg(input csr_reg_type r, input logic [3:0] v);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 4'(int'(r) * CSR_STRIDE);
      csr_pwdata  <= {28'h0, v};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // stop sending and let every outstanding item come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic random_burst();
      int         pick;
      int         n;
      int         k;
      int         start;
      bit         abandon;
      logic [7:0] data;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         // write transaction, biased to cover the colon addresses
         start   = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(2, 6);
         n       = $urandom_range(0, 6);
         abandon = ($urandom_range(0, 9) == 0);
         send(FUNC_BUS_BYTE, {CMD_SET_ADDR, 4'(start)}, 1'b1, n == 0 && !abandon);
         for (k = 0; k < n; k++) begin
            if (4'(start + k) == COLON_ADDR) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: data = COLON_ON;
                  4, 5, 6:    data = COLON_OFF;
                  default:    data = 8'($urandom);
               endcase
            end else begin
               data = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0)
               send(FUNC_SCAN_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            send(FUNC_BUS_BYTE, data, 1'b0, k == n - 1 && !abandon);
         end
      end else if (pick < 75) begin
         n = $urandom_range(1, 6);
         for (k = 0; k < n; k++)
            send(FUNC_SCAN_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 83) begin
         send(FUNC_BUS_BYTE, {CMD_DIMMING, 4'($urandom)}, 1'b1, 1'($urandom));
      end else if (pick < 88) begin
         send(FUNC_BUS_BYTE, {4'($urandom_range(1, 13)), 4'($urandom)}, 1'b1,
              1'($urandom));
      end else begin
         send(func_type'($urandom_range(0, 1)), 8'($urandom), 1'($urandom),
              1'($urandom));
      end
   endtask

   initial begin
      int         target;
      logic [3:0] addr_set [4];
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_BUS_BYTE;
      req_bus_byte   = '0;
      req_first_byte = 1'b0;
      req_final_byte = 1'b0;
      rsp_stall      = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed part, on the reset digit addresses
      send(FUNC_SCAN_TICK, 8'hFF, 1'b1, 1'b1);
      send(FUNC_BUS_BYTE, 8'h55, 1'b0, 1'b0);             // data with no write open
      send(FUNC_BUS_BYTE, {CMD_DIMMING, 4'h0}, 1'b1, 1'b1);
      send(FUNC_BUS_BYTE, {CMD_DIMMING, 4'hF}, 1'b1, 1'b0);
      send(FUNC_BUS_BYTE, {CMD_OTHER, 4'hA}, 1'b1, 1'b0);  // unknown command
      send(FUNC_BUS_BYTE, 8'hFF, 1'b0, 1'b1);
      send(FUNC_BUS_BYTE, {CMD_SET_ADDR, LEFT_ADDR}, 1'b1, 1'b0);
      send(FUNC_BUS_BYTE, 8'hFF, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, 8'h00, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, COLON_ON, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, 8'hFF, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, 8'h80, 1'b0, 1'b1);
      repeat (4) send(FUNC_SCAN_TICK, 8'h00, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, {CMD_SET_ADDR, COLON_ADDR}, 1'b1, 1'b0);
      send(FUNC_BUS_BYTE, COLON_OFF, 1'b0, 1'b1);
      // restart mid-write, then wrap the pointer past the top
      send(FUNC_BUS_BYTE, {CMD_SET_ADDR, COLON_ADDR}, 1'b1, 1'b0);
      send(FUNC_BUS_BYTE, 8'h5A, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, {CMD_SET_ADDR, 4'hF}, 1'b1, 1'b0);
      send(FUNC_BUS_BYTE, 8'hAA, 1'b0, 1'b0);
      send(FUNC_BUS_BYTE, 8'h11, 1'b0, 1'b1);
      send(FUNC_BUS_BYTE, {CMD_SET_ADDR, 4'hC}, 1'b1, 1'b1); // command-only write
      repeat (2) send(FUNC_SCAN_TICK, 8'h00, 1'b0, 1'b0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         for (int r = 0; r < 4; r++) begin
            case (phase)
               0:       addr_set[r] = 4'h0;
               1:       addr_set[r] = 4'hF;
               default: addr_set[r] = 4'($urandom);
            endcase
            write_reg(csr_reg_type'(r), addr_set[r]);
         end
         quiet  = (phase == 2);
         target = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < target)
            random_burst();
      end
      quiet = 1'b0;
      drain();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/sseg_pkg.sv
rtl/core/sseg_csr.sv
rtl/core/sseg_ctrl.sv
rtl/core/sseg_dp.sv
rtl/core/sseg_outq.sv
rtl/core/seven_segment_display_controller.sv
rtl/core/sseg_checker.sv
tb/sv/sseg_tb_pkg.sv
tb/sv/sseg_display_checker.sv
tb/sv/tb_top.sv
